### hw/rtl/bsbr_pkg.sv
package bsbr_pkg;

   // Storage shape
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Field widths
   localparam int OPCODE_W      = 3;
   localparam int INDEX_W       = 4;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 5;

   localparam int REQ_TDATA_W = ((DATA_WIDTH + INDEX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_WIDTH + STATUS_W + COUNT_FIELD_W + 7) / 8) * 8;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_PUSH          = 3'd0;
   localparam opcode_type OP_POP           = 3'd1;
   localparam opcode_type OP_PEEK          = 3'd2;
   localparam opcode_type OP_READ_AT       = 3'd3;
   localparam opcode_type OP_REMOVE_BOTTOM = 3'd4;

   localparam status_type STAT_OK      = 2'd0;
   localparam status_type STAT_EMPTY   = 2'd1;
   localparam status_type STAT_INVALID = 2'd2;
   localparam status_type STAT_FULL    = 2'd3;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request, launch store read
      logic commit;  // update state, write store, load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_busy;  // result register full and not taken this cycle
   } dp_stat_type;

endpackage

### hw/rtl/bounded_stack_with_bottom_removal.sv
// Channel  Ports                         Contents
// -------  ----------------------------  -------------------------------------------
// request  req_tvalid/tready/tdata/tuser tuser: opcode; tdata: push_value, depth_index
// result   rsp_tvalid/tready/tdata       tdata: read_value, status, entry_count
//
// Each request is handled in S_IDLE, which launches the store read, then in S_EXEC, which
// forms the result from the registered read port of the entry RAM. One request is in
// flight at a time. A new request is taken while the previous result still waits on
// rsp_tready; it then holds in S_EXEC until the result register frees up.
// Reset clears the count, ring base and result valid; the store is not cleared.
module bounded_stack_with_bottom_removal (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] push_value, [35:32] depth_index, rest zero
   input  logic [bsbr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] opcode
   input  logic [bsbr_pkg::OPCODE_W-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] read_value, [33:32] status, [38:34] entry_count, rest zero
   output logic [bsbr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   bsbr_pkg::cmd_type     cmd;
   bsbr_pkg::dp_stat_type dp_stat;

   bsbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_stat    (dp_stat),
      .cmd        (cmd)
   );

   bsbr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_stat    (dp_stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hw/rtl/bsbr_ram.sv
module bsbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bsbr_ctrl.sv
module bsbr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bsbr_pkg::dp_stat_type dp_stat,
   output bsbr_pkg::cmd_type     cmd
);

   bsbr_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsbr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         bsbr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = bsbr_pkg::S_EXEC;
            end
         end
         bsbr_pkg::S_EXEC: begin
            // store read data is ready; wait for room in the result register
            if (!dp_stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = bsbr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsbr_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/bsbr_dp.sv
module bsbr_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bsbr_pkg::cmd_type                     cmd,
   output bsbr_pkg::dp_stat_type                 dp_stat,
   input  logic [bsbr_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic [bsbr_pkg::OPCODE_W-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bsbr_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int CMP_W = (bsbr_pkg::CNT_W > bsbr_pkg::INDEX_W) ?
                          bsbr_pkg::CNT_W : bsbr_pkg::INDEX_W;

   function automatic logic [bsbr_pkg::ADDR_W-1:0] ring_add(
      input logic [bsbr_pkg::ADDR_W-1:0] a,
      input logic [bsbr_pkg::ADDR_W-1:0] b
   );
      logic [bsbr_pkg::ADDR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (bsbr_pkg::ADDR_W + 1)'(bsbr_pkg::DEPTH)) begin
         sum = sum - (bsbr_pkg::ADDR_W + 1)'(bsbr_pkg::DEPTH);
      end
      return sum[bsbr_pkg::ADDR_W-1:0];
   endfunction

   // Captured request
   bsbr_pkg::opcode_type              op_ff;
   logic [bsbr_pkg::DATA_WIDTH-1:0]   value_ff;
   logic [bsbr_pkg::INDEX_W-1:0]      index_ff;

   // Ring state
   logic [bsbr_pkg::ADDR_W-1:0]       bottom_ff, bottom_in;
   logic [bsbr_pkg::CNT_W-1:0]        count_ff, count_in;

   // Result register
   logic                              rsp_valid_ff;
   logic [bsbr_pkg::DATA_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   bsbr_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [bsbr_pkg::CNT_W-1:0]        rsp_count_ff;

   // Incoming request fields
   bsbr_pkg::opcode_type              req_op;
   logic [bsbr_pkg::DATA_WIDTH-1:0]   req_value;
   logic [bsbr_pkg::INDEX_W-1:0]      req_index;

   // Store access
   logic [bsbr_pkg::CNT_W-1:0]        rd_offset;
   logic [bsbr_pkg::ADDR_W-1:0]       rd_addr;
   logic [bsbr_pkg::ADDR_W-1:0]       wr_addr;
   logic                              wr_en;
   logic [bsbr_pkg::DATA_WIDTH-1:0]   rd_data;
   logic                              is_empty;
   logic                              is_full;
   logic                              index_bad;

   assign req_op    = req_tuser;
   assign req_value = req_tdata[bsbr_pkg::DATA_WIDTH-1:0];
   assign req_index = req_tdata[bsbr_pkg::DATA_WIDTH +: bsbr_pkg::INDEX_W];

   // Slot below top = bottom + count - 1 - places; oldest entry sits at bottom
   always_comb begin
      if (req_op == bsbr_pkg::OP_REMOVE_BOTTOM) begin
         rd_offset = '0;
      end else if (req_op == bsbr_pkg::OP_READ_AT) begin
         rd_offset = count_ff - bsbr_pkg::CNT_W'(1) -
                     bsbr_pkg::CNT_W'(req_index);
      end else begin
         rd_offset = count_ff - bsbr_pkg::CNT_W'(1);
      end
   end

   assign rd_addr = ring_add(bottom_ff, bsbr_pkg::ADDR_W'(rd_offset));
   assign wr_addr = ring_add(bottom_ff, bsbr_pkg::ADDR_W'(count_ff));

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == bsbr_pkg::CNT_W'(bsbr_pkg::DEPTH));
   assign index_bad = (CMP_W'(index_ff) >= CMP_W'(count_ff));

   bsbr_ram #(
      .WIDTH (bsbr_pkg::DATA_WIDTH),
      .DEPTH (bsbr_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.load),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      bottom_in     = bottom_ff;
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_status_in = bsbr_pkg::STAT_OK;
      wr_en         = 1'b0;
      unique case (op_ff)
         bsbr_pkg::OP_PUSH: begin
            if (is_full) begin
               rsp_status_in = bsbr_pkg::STAT_FULL;
            end else begin
               wr_en    = cmd.commit;
               count_in = count_ff + bsbr_pkg::CNT_W'(1);
            end
         end
         bsbr_pkg::OP_POP: begin
            if (is_empty) begin
               rsp_status_in = bsbr_pkg::STAT_EMPTY;
            end else begin
               rsp_value_in = rd_data;
               count_in     = count_ff - bsbr_pkg::CNT_W'(1);
            end
         end
         bsbr_pkg::OP_PEEK: begin
            if (is_empty) begin
               rsp_status_in = bsbr_pkg::STAT_EMPTY;
            end else begin
               rsp_value_in = rd_data;
            end
         end
         bsbr_pkg::OP_READ_AT: begin
            if (index_bad) begin
               rsp_status_in = bsbr_pkg::STAT_INVALID;
            end else begin
               rsp_value_in = rd_data;
            end
         end
         bsbr_pkg::OP_REMOVE_BOTTOM: begin
            if (is_empty) begin
               rsp_status_in = bsbr_pkg::STAT_EMPTY;
            end else begin
               rsp_value_in = rd_data;
               bottom_in    = ring_add(bottom_ff, bsbr_pkg::ADDR_W'(1));
               count_in     = count_ff - bsbr_pkg::CNT_W'(1);
            end
         end
         default: begin
            rsp_status_in = bsbr_pkg::STAT_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         index_ff <= req_index;
      end
      if (cmd.commit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            bottom_ff <= bottom_in;
            count_ff  <= count_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign dp_stat.out_busy = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bsbr_pkg::RSP_TDATA_W'({
      bsbr_pkg::COUNT_FIELD_W'(rsp_count_ff), rsp_status_ff, rsp_value_ff});

endmodule

### hw/rtl/bsbr_chk.sv
module bsbr_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bsbr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int VAL_LO = 0;
   localparam int ST_LO  = bsbr_pkg::DATA_WIDTH;
   localparam int CNT_LO = bsbr_pkg::DATA_WIDTH + bsbr_pkg::STATUS_W;

   logic [bsbr_pkg::DATA_WIDTH-1:0]    rsp_value;
   bsbr_pkg::status_type               rsp_status;
   logic [bsbr_pkg::COUNT_FIELD_W-1:0] rsp_count;

   assign rsp_value  = rsp_tdata[VAL_LO +: bsbr_pkg::DATA_WIDTH];
   assign rsp_status = rsp_tdata[ST_LO +: bsbr_pkg::STATUS_W];
   assign rsp_count  = rsp_tdata[CNT_LO +: bsbr_pkg::COUNT_FIELD_W];

   // result held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // one request in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= bsbr_pkg::COUNT_FIELD_W'(bsbr_pkg::DEPTH))
      else $error("entry count beyond depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == bsbr_pkg::STAT_FULL |->
         rsp_count == bsbr_pkg::COUNT_FIELD_W'(bsbr_pkg::DEPTH) && rsp_value == '0)
      else $error("full status with wrong count or nonzero value");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == bsbr_pkg::STAT_EMPTY |->
         rsp_count == '0 && rsp_value == '0)
      else $error("empty status with wrong count or nonzero value");

endmodule

bind bounded_stack_with_bottom_removal bsbr_chk u_bsbr_chk (.*);
